// ===== sv/prs_pkg.sv =====
// ============================================================================
// prs_pkg - shared types and constants of the pointer relocation scanner
// Region table sizing, operation and register codes, controller/datapath
// command and status bundles.
// ============================================================================
package prs_pkg;

    // Region table
    localparam int MAX_REGIONS = 64;
    localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
    localparam int IDX_W       = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;

    // Field widths
    localparam int ADDR_W  = 64;
    localparam int KIND_W  = 3;
    localparam int OP_W    = 2;
    localparam int CNT32_W = 32;
    localparam int ENTRY_W = ADDR_W + ADDR_W + KIND_W;

    // Stream packing
    localparam int S_TDATA_W = 200;   // 195 bits of fields, padded to bytes
    localparam int M_TDATA_W = 136;   // 131 bits of fields, padded to bytes

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam int NUM_OFFSETS = 5;

    // Operation codes
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
    localparam logic [OP_W-1:0] OP_SCAN  = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_CODE_OFS  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DATA_OFS  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_HEAP_OFS  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_STACK_OFS = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_MMAP_OFS  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_CONS_MODE = 3'd5;

    // Region kinds
    localparam logic [KIND_W-1:0] KIND_CODE  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DATA  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_HEAP  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_STACK = 3'd3;
    localparam logic [KIND_W-1:0] KIND_MMAP  = 3'd4;

    typedef struct packed {
        logic latch;      // capture the accepted beat
        logic exec;       // apply the operation to table, span and counts
        logic scan_step;  // walk the region table
        logic emit;       // load the result into the output register
    } prs_cmd_t;

    typedef struct packed {
        logic need_scan;  // found word with a non-empty table
        logic scan_done;  // first match found or table exhausted
        logic out_free;   // output register can take a result
    } prs_sts_t;

    function automatic logic [CNT32_W-1:0] sat_inc(input logic [CNT32_W-1:0] v);
        sat_inc = (&v) ? v : v + CNT32_W'(1);
    endfunction

endpackage

// ===== sv/pointer_relocation_scanner.sv =====
// ============================================================================
// pointer_relocation_scanner - relocates 64-bit pointers in a memory dump
// Region table with first-match lookup and per-kind offsets.
// ============================================================================
// One beat in gives one beat out. s_tuser carries the operation: clear,
// load region, scan word or no-op. Each beat is latched and executed, and
// its result is loaded into the output register. A scan whose word falls
// inside the span of loaded regions, with some offset non-zero, also walks
// the region table from entry 0 up to the first matching region, or to the
// last loaded region when none matches, through the table's single read
// port, which yields one entry per cycle to the range compare. The next
// beat is taken once the result is in the output register, even while the
// output side stalls; a second result waits for the first to be taken.
// Offsets and conservative mode are written through the cfg_ port; the
// user must write them only while idle, which the block does not enforce.
// A clear keeps them. The table itself needs no clearing pass: only
// entries below the region count are ever read.
module pointer_relocation_scanner (
    input  logic                                aclk,
    input  logic                                aresetn,
    // slave side
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // region_start[63:0], region_end[127:64], region_kind[130:128],
    // word_value[194:131], zero pad
    input  logic [prs_pkg::S_TDATA_W-1:0]       s_tdata,
    // op[1:0]
    input  logic [prs_pkg::OP_W-1:0]            s_tuser,
    // master side
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // word_out[63:0], pointer_found[64], relocated[65], found_total[97:66],
    // relocated_total[129:98], status[130], zero pad
    output logic [prs_pkg::M_TDATA_W-1:0]       m_tdata,
    // configuration
    input  logic                                cfg_wr_en,
    input  logic [prs_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [prs_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import prs_pkg::*;

    prs_cmd_t cmd;
    prs_sts_t sts;

    // sequencing
    prs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // table, span, counters and the relocation adder
    prs_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_op           (s_tuser),
        .in_region_start (s_tdata[63:0]),
        .in_region_end   (s_tdata[127:64]),
        .in_region_kind  (s_tdata[130:128]),
        .in_word_value   (s_tdata[194:131]),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .cmd             (cmd),
        .sts             (sts),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata)
    );

endmodule

// ===== sv/prs_ram.sv =====
// ============================================================================
// prs_ram - generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ============================================================================
module prs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      aclk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            ram_reg[waddr] <= wdata;
        end
        rdata_reg <= ram_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/prs_ctrl.sv =====
// ============================================================================
// prs_ctrl - sequencing controller
// Accepts one beat, runs the operation, walks the table for scans and
// hands the result to the output register.
// ============================================================================
module prs_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output prs_pkg::prs_cmd_t cmd,
    input  prs_pkg::prs_sts_t sts
);
    import prs_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_EXEC   = 2'd1;
    localparam logic [1:0] ST_SCAN   = 2'd2;
    localparam logic [1:0] ST_RESULT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next    = state_reg;
        cmd.latch     = 1'b0;
        cmd.exec      = 1'b0;
        cmd.scan_step = 1'b0;
        cmd.emit      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.latch  = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = sts.need_scan ? ST_SCAN : ST_RESULT;
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sv/prs_dp.sv =====
// ============================================================================
// prs_dp - scanner datapath
// Offset registers, region table, span and counters, table walk and the
// relocation adder feeding the output register.
// ============================================================================
module prs_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [prs_pkg::OP_W-1:0]            in_op,
    input  logic [prs_pkg::ADDR_W-1:0]          in_region_start,
    input  logic [prs_pkg::ADDR_W-1:0]          in_region_end,
    input  logic [prs_pkg::KIND_W-1:0]          in_region_kind,
    input  logic [prs_pkg::ADDR_W-1:0]          in_word_value,
    input  logic                                cfg_wr_en,
    input  logic [prs_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [prs_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  prs_pkg::prs_cmd_t                   cmd,
    output prs_pkg::prs_sts_t                   sts,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [prs_pkg::M_TDATA_W-1:0]       m_tdata
);
    import prs_pkg::*;

    // configuration
    logic [ADDR_W-1:0] offset_reg [NUM_OFFSETS];
    logic              cons_mode_reg;

    // latched beat
    logic [OP_W-1:0]   op_reg;
    logic [ADDR_W-1:0] start_in_reg;
    logic [ADDR_W-1:0] end_in_reg;
    logic [KIND_W-1:0] kind_in_reg;
    logic [ADDR_W-1:0] word_reg;

    // table state and totals
    logic [CNT_W-1:0]   region_count_reg, region_count_next;
    logic [ADDR_W-1:0]  span_low_reg, span_low_next;
    logic [ADDR_W-1:0]  span_high_reg, span_high_next;
    logic [CNT32_W-1:0] found_count_reg, found_count_next;
    logic [CNT32_W-1:0] moved_count_reg, moved_count_next;

    // per-item results
    logic              found_reg;
    logic              status_reg;
    logic              hit_reg;
    logic [KIND_W-1:0] hit_kind_reg;

    // table walk
    logic [CNT_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic             dvalid_reg;
    logic             last_reg;

    // output register
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;

    // ------------------------------------------------------------------
    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_OFFSETS; i++) begin
                offset_reg[i] <= '0;
            end
            cons_mode_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_CODE_OFS:  offset_reg[0] <= cfg_wdata;
                REG_DATA_OFS:  offset_reg[1] <= cfg_wdata;
                REG_HEAP_OFS:  offset_reg[2] <= cfg_wdata;
                REG_STACK_OFS: offset_reg[3] <= cfg_wdata;
                REG_MMAP_OFS:  offset_reg[4] <= cfg_wdata;
                REG_CONS_MODE: cons_mode_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // beat capture
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            op_reg       <= in_op;
            start_in_reg <= in_region_start;
            end_in_reg   <= in_region_end;
            kind_in_reg  <= in_region_kind;
            word_reg     <= in_word_value;
        end
    end

    // ------------------------------------------------------------------
    // operation decode
    logic any_offset;
    logic in_span;
    logic word_found;
    logic table_full;
    logic do_store;

    assign any_offset = (offset_reg[0] | offset_reg[1] | offset_reg[2] |
                         offset_reg[3] | offset_reg[4]) != '0;
    assign in_span    = (word_reg >= span_low_reg) && (word_reg < span_high_reg);
    assign word_found = (op_reg == OP_SCAN) && any_offset && in_span;
    assign table_full = (region_count_reg == CNT_W'(MAX_REGIONS));
    assign do_store   = cmd.exec && (op_reg == OP_LOAD) && !table_full;

    // ------------------------------------------------------------------
    // region table
    logic [ENTRY_W-1:0] rd_entry;
    logic [ADDR_W-1:0]  ent_start;
    logic [ADDR_W-1:0]  ent_end;
    logic [KIND_W-1:0]  ent_kind;

    prs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_REGIONS)
    ) u_table (
        .aclk  (aclk),
        .we    (do_store),
        .waddr (region_count_reg[IDX_W-1:0]),
        .wdata ({kind_in_reg, end_in_reg, start_in_reg}),
        .raddr (rd_ptr_reg[IDX_W-1:0]),
        .rdata (rd_entry)
    );

    assign ent_start = rd_entry[ADDR_W-1:0];
    assign ent_end   = rd_entry[2*ADDR_W-1:ADDR_W];
    assign ent_kind  = rd_entry[ENTRY_W-1:2*ADDR_W];

    // walk: one address issued per cycle, entry checked in the cycle after
    logic ent_match;
    logic scan_done;
    logic issue;

    assign ent_match = dvalid_reg && (word_reg >= ent_start) && (word_reg < ent_end);
    assign scan_done = dvalid_reg && (ent_match || last_reg);
    assign issue     = cmd.scan_step && !scan_done && (rd_ptr_reg < region_count_reg);

    always_comb begin
        rd_ptr_next = rd_ptr_reg;
        if (cmd.exec) begin
            rd_ptr_next = '0;
        end else if (issue) begin
            rd_ptr_next = rd_ptr_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= '0;
            dvalid_reg <= 1'b0;
        end else begin
            rd_ptr_reg <= rd_ptr_next;
            dvalid_reg <= issue;
        end
        last_reg <= (rd_ptr_reg == region_count_reg - CNT_W'(1));
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            hit_reg    <= 1'b0;
            found_reg  <= word_found;
            status_reg <= (op_reg == OP_LOAD) && table_full;
        end else if (cmd.scan_step && ent_match) begin
            hit_reg      <= 1'b1;
            hit_kind_reg <= ent_kind;
        end
    end

    // ------------------------------------------------------------------
    // relocation
    logic [ADDR_W-1:0] kind_offset;
    logic              kind_allowed;
    logic [ADDR_W-1:0] moved_word;
    logic              moved;

    always_comb begin
        unique case (hit_kind_reg)
            KIND_CODE:  kind_offset = offset_reg[0];
            KIND_DATA:  kind_offset = offset_reg[1];
            KIND_HEAP:  kind_offset = offset_reg[2];
            KIND_STACK: kind_offset = offset_reg[3];
            KIND_MMAP:  kind_offset = offset_reg[4];
            default:    kind_offset = '0;
        endcase
    end

    assign kind_allowed = !cons_mode_reg || (hit_kind_reg == KIND_CODE) ||
                          (hit_kind_reg == KIND_HEAP) || (hit_kind_reg == KIND_STACK);
    assign moved_word   = word_reg + kind_offset;
    assign moved        = found_reg && hit_reg && kind_allowed && (moved_word != word_reg);

    // ------------------------------------------------------------------
    // table state and totals
    always_comb begin
        region_count_next = region_count_reg;
        span_low_next     = span_low_reg;
        span_high_next    = span_high_reg;
        found_count_next  = found_count_reg;
        moved_count_next  = moved_count_reg;
        if (cmd.exec && (op_reg == OP_CLEAR)) begin
            region_count_next = '0;
            span_low_next     = '1;
            span_high_next    = '0;
            found_count_next  = '0;
            moved_count_next  = '0;
        end else if (do_store) begin
            region_count_next = region_count_reg + CNT_W'(1);
            if (start_in_reg < span_low_reg) begin
                span_low_next = start_in_reg;
            end
            if (end_in_reg > span_high_reg) begin
                span_high_next = end_in_reg;
            end
        end else if (cmd.exec && word_found) begin
            found_count_next = sat_inc(found_count_reg);
        end else if (cmd.emit && moved) begin
            moved_count_next = sat_inc(moved_count_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            region_count_reg <= '0;
            span_low_reg     <= '1;
            span_high_reg    <= '0;
            found_count_reg  <= '0;
            moved_count_reg  <= '0;
        end else begin
            region_count_reg <= region_count_next;
            span_low_reg     <= span_low_next;
            span_high_reg    <= span_high_next;
            found_count_reg  <= found_count_next;
            moved_count_reg  <= moved_count_next;
        end
    end

    // ------------------------------------------------------------------
    // output register
    logic [ADDR_W-1:0] word_out;

    assign word_out = (op_reg != OP_SCAN) ? '0 : (moved ? moved_word : word_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (cmd.emit) begin
            out_data_reg <= {5'b0, status_reg, moved_count_next, found_count_reg,
                             moved, found_reg, word_out};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign sts.need_scan = word_found && (region_count_reg != '0);
    assign sts.scan_done = scan_done;
    assign sts.out_free  = !out_valid_reg || m_tready;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        region_count_reg <= CNT_W'(MAX_REGIONS))
        else $error("region count beyond table depth");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!out_valid_reg || m_tready))
        else $error("result written over an untaken beat");

    a_done_in_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_done |-> cmd.scan_step)
        else $error("table walk finished outside a scan");

    a_found_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.exec && (op_reg == OP_CLEAR)) |=> found_count_reg >= $past(found_count_reg))
        else $error("found total fell without a clear");
`endif

endmodule

// ===== bench/prs_tb_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// prs_tb_pkg - result scoreboard for the pointer relocation scanner bench
// Keeps its own copy of the region table, span, counts and offsets, works
// out the result beat of every accepted input beat and checks the result
// stream against those expectations in order.
// ============================================================================
package prs_tb_pkg;
    import prs_pkg::*;

    typedef struct {
        logic [ADDR_W-1:0]  word;
        logic               found;
        logic               moved;
        logic [CNT32_W-1:0] found_total;
        logic [CNT32_W-1:0] moved_total;
        logic               status;
    } reloc_result_t;

    class reloc_scoreboard;
        logic [ADDR_W-1:0]  tab_lo   [MAX_REGIONS];
        logic [ADDR_W-1:0]  tab_hi   [MAX_REGIONS];
        logic [KIND_W-1:0]  tab_kind [MAX_REGIONS];
        int                 regions;
        logic [ADDR_W-1:0]  span_lo;
        logic [ADDR_W-1:0]  span_hi;
        logic [CNT32_W-1:0] found_cnt;
        logic [CNT32_W-1:0] moved_cnt;
        logic [ADDR_W-1:0]  kind_offset [NUM_OFFSETS];
        bit                 conservative;
        reloc_result_t      expected_results [$];
        int                 mismatches;
        int                 checked;
        int                 scans, finds, moves, loads, drops, clears;

        function new();
            foreach (kind_offset[i]) kind_offset[i] = '0;
            conservative = 1'b0;
            clear_regions();
        endfunction

        function void clear_regions();
            regions   = 0;
            span_lo   = '1;
            span_hi   = '0;
            found_cnt = '0;
            moved_cnt = '0;
        endfunction

        function void set_register(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_CODE_OFS:  kind_offset[KIND_CODE]  = value;
                REG_DATA_OFS:  kind_offset[KIND_DATA]  = value;
                REG_HEAP_OFS:  kind_offset[KIND_HEAP]  = value;
                REG_STACK_OFS: kind_offset[KIND_STACK] = value;
                REG_MMAP_OFS:  kind_offset[KIND_MMAP]  = value;
                REG_CONS_MODE: conservative = value[0];
                default: ;
            endcase
        endfunction

        function logic [CNT32_W-1:0] bump(logic [CNT32_W-1:0] cnt);
            return (cnt == '1) ? cnt : cnt + 1'b1;
        endfunction

        // Works out the result of one accepted beat and queues it
        function void note_request(logic [OP_W-1:0] op, logic [ADDR_W-1:0] lo,
                                   logic [ADDR_W-1:0] hi, logic [KIND_W-1:0] kind,
                                   logic [ADDR_W-1:0] w);
            reloc_result_t     r;
            logic [ADDR_W-1:0] any_ofs;
            logic [ADDR_W-1:0] shifted;
            logic [KIND_W-1:0] hit_kind;
            int                hit;
            int                i;
            bit                allowed;

            r = '{default: '0};
            case (op)
                OP_CLEAR: begin
                    clear_regions();
                    clears++;
                end
                OP_LOAD: begin
                    loads++;
                    if (regions < MAX_REGIONS) begin
                        tab_lo[regions]   = lo;
                        tab_hi[regions]   = hi;
                        tab_kind[regions] = kind;
                        regions++;
                        if (lo < span_lo) span_lo = lo;
                        if (hi > span_hi) span_hi = hi;
                    end else begin
                        r.status = 1'b1;
                        drops++;
                    end
                end
                OP_SCAN: begin
                    scans++;
                    r.word  = w;
                    any_ofs = kind_offset[0] | kind_offset[1] | kind_offset[2] |
                              kind_offset[3] | kind_offset[4];
                    if (any_ofs != '0 && w >= span_lo && w < span_hi) begin
                        r.found   = 1'b1;
                        found_cnt = bump(found_cnt);
                        finds++;
                        hit = -1;
                        for (i = 0; i < regions; i++) begin
                            if (hit < 0 && w >= tab_lo[i] && w < tab_hi[i]) hit = i;
                        end
                        if (hit >= 0) begin
                            hit_kind = tab_kind[hit];
                            allowed  = !conservative || hit_kind == KIND_CODE ||
                                       hit_kind == KIND_HEAP || hit_kind == KIND_STACK;
                            // kinds above mmap carry no offset at all
                            if (allowed && hit_kind <= KIND_MMAP) begin
                                shifted = w + kind_offset[hit_kind];
                                if (shifted != w) begin
                                    r.word    = shifted;
                                    r.moved   = 1'b1;
                                    moved_cnt = bump(moved_cnt);
                                    moves++;
                                end
                            end
                        end
                    end
                end
                default: ;
            endcase
            r.found_total = found_cnt;
            r.moved_total = moved_cnt;
            expected_results.insert(expected_results.size(), r);
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        task report_mismatch(string what);
            if (mismatches < 20) $display("[%0t] MISMATCH result %0d: %s", $time, checked, what);
            mismatches++;
        endtask

        task compare_field(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %h want %h", name, got, want));
        endtask

        task check_result(logic [M_TDATA_W-1:0] beat);
            reloc_result_t want;

            if (expected_results.size() == 0) begin
                report_mismatch("result beat with nothing outstanding");
            end else begin
                want = expected_results.pop_front();
                compare_field("word_out", beat[63:0], want.word);
                compare_field("pointer_found", 64'(beat[64]), 64'(want.found));
                compare_field("relocated", 64'(beat[65]), 64'(want.moved));
                compare_field("found_total", 64'(beat[97:66]), 64'(want.found_total));
                compare_field("relocated_total", 64'(beat[129:98]), 64'(want.moved_total));
                compare_field("status", 64'(beat[130]), 64'(want.status));
            end
            checked++;
        endtask
    endclass

endpackage

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_top - bench for the pointer relocation scanner
// Directed beats over every operation, region kind and edge of the span,
// then random clear/load/scan episodes under several offset settings, with
// random gaps on both stream sides and every result checked in order.
// ============================================================================
module tb_top;
    import prs_pkg::*;
    import prs_tb_pkg::*;

    // Longest quiet spell on both streams before the run is called hung.
    // A correct run is never quiet for more than a scan over a full table
    // plus a stalled output, a sender gap and the closing wait.
    localparam int HANG_LIMIT = 4000;
    localparam int IDLE_PCT   = 38;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [OP_W-1:0]       s_tuser   = OP_NOP;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = REG_CODE_OFS;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    reloc_scoreboard board;
    bit              steady_flow;     // no idling on either side while set
    int              beats_sent;
    int              quiet_cycles;

    // addresses of regions sent since the last clear, used to aim scans
    logic [ADDR_W-1:0] planted_lo [$];
    logic [ADDR_W-1:0] planted_hi [$];

    pointer_relocation_scanner dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #10 aclk = ~aclk;

    // Result side back-pressure, changed on the falling edge only
    always @(negedge aclk) begin
        m_tready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Result monitor and hang watchdog, both on the rising edge
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_result(m_tdata);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= HANG_LIMIT) begin
            $display("[%0t] no beat moved for %0d cycles", $time, HANG_LIMIT);
            $display("pointer_relocation_scanner verification failed");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Offsets lean on the extremes: zero, -1, most negative, most positive
    function automatic logic [63:0] pick_offset();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 64'h8000_0000_0000_0000;
            3: return 64'h7fff_ffff_ffff_ffff;
            4: return 64'($urandom_range(1, 65535));
            5: return -64'($urandom_range(1, 65535));
            default: return rand64();
        endcase
    endfunction

    // One input beat. The first falling edge after the previous acceptance
    // always gets exactly one assignment to s_tvalid: low for a gap, or high
    // with the new beat.
    task automatic send_beat(input logic [OP_W-1:0] op, input logic [63:0] lo,
                             input logic [63:0] hi, input logic [KIND_W-1:0] kind,
                             input logic [63:0] w);
        @(negedge aclk);
        while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {5'b0, w, kind, hi, lo};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_request(op, lo, hi, kind, w);
        beats_sent++;
    endtask

    // Holds the input side off until every outstanding result has arrived
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [63:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        board.set_register(idx, value);
    endtask

    // Only called with the block idle (after drain_results)
    task automatic program_offsets(input logic [63:0] code_ofs, input logic [63:0] data_ofs,
                                   input logic [63:0] heap_ofs, input logic [63:0] stack_ofs,
                                   input logic [63:0] mmap_ofs, input bit cons);
        write_reg(REG_CODE_OFS, code_ofs);
        write_reg(REG_DATA_OFS, data_ofs);
        write_reg(REG_HEAP_OFS, heap_ofs);
        write_reg(REG_STACK_OFS, stack_ofs);
        write_reg(REG_MMAP_OFS, mmap_ofs);
        write_reg(REG_CONS_MODE, 64'(cons));
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic load_region(input logic [63:0] lo, input logic [63:0] hi,
                               input logic [KIND_W-1:0] kind);
        send_beat(OP_LOAD, lo, hi, kind, rand64());
    endtask

    task automatic scan_word(input logic [63:0] w);
        send_beat(OP_SCAN, rand64(), rand64(), KIND_W'($urandom), w);
    endtask

    // A clear (usually), a run of region loads, then scans mostly aimed at
    // the loaded regions and their edges. A filling episode loads two more
    // regions than the table holds, so the last two are refused.
    task automatic run_episode(input bit fill_table);
        int                n_regions;
        int                n_scans;
        int                k;
        int                idx;
        int                pick;
        logic [63:0]       lo;
        logic [63:0]       hi;
        logic [63:0]       span;
        logic [63:0]       w;
        logic [KIND_W-1:0] kind;

        if (fill_table || $urandom_range(0, 3) != 0) begin
            send_beat(OP_CLEAR, rand64(), rand64(), KIND_W'($urandom), rand64());
            planted_lo.delete();
            planted_hi.delete();
        end
        n_regions = fill_table ? MAX_REGIONS + 2 : $urandom_range(1, 8);
        for (k = 0; k < n_regions; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 15 && planted_lo.size() != 0) begin
                // starts up to 255 above an earlier region's start: the first match must win
                idx = $urandom_range(0, planted_lo.size() - 1);
                lo  = planted_lo[idx] + 64'($urandom_range(0, 255));
                hi  = lo + 64'($urandom_range(1, 4096));
            end else begin
                lo = rand64();
                case ($urandom_range(0, 2))
                    0: span = 64'($urandom_range(1, 4096));
                    1: span = 64'($urandom);
                    default: span = {16'b0, 16'($urandom), $urandom};
                endcase
                hi = lo + span;
            end
            if (pick >= 95) begin
                hi = lo;                     // empty region
            end else if (pick >= 90) begin
                w  = lo;                     // inverted region
                lo = hi;
                hi = w;
            end
            kind = ($urandom_range(0, 9) < 8) ? KIND_W'($urandom_range(0, 4))
                                              : KIND_W'($urandom_range(5, 7));
            load_region(lo, hi, kind);
            planted_lo.insert(planted_lo.size(), lo);
            planted_hi.insert(planted_hi.size(), hi);
        end
        n_scans = $urandom_range(3, 14);
        for (k = 0; k < n_scans; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 65 && planted_lo.size() != 0) begin
                idx = $urandom_range(0, planted_lo.size() - 1);
                lo  = planted_lo[idx];
                hi  = planted_hi[idx];
                if (hi <= lo)      w = lo;
                else if (pick < 50) w = lo + rand64() % (hi - lo);
                else if (pick < 55) w = lo;
                else if (pick < 60) w = hi - 1'b1;
                else               w = hi;
                scan_word(w);
            end else if (pick < 85) begin
                scan_word(rand64());
            end else if (pick < 95) begin
                scan_word(64'($urandom));
            end else begin
                send_beat(OP_NOP, rand64(), rand64(), KIND_W'($urandom), rand64());
            end
        end
    endtask

    initial begin
        int budget;
        int phase;
        bit paused;

        board       = new();
        steady_flow = 1'b0;
        beats_sent  = 0;
        paused      = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // --- directed: offsets still all zero, so nothing is found
        load_region(64'h1000, 64'h2000, KIND_CODE);
        scan_word(64'h1800);
        send_beat(OP_NOP, '1, '1, '1, '1);

        // mmap offset left at zero to get a found word with zero net move
        drain_results();
        program_offsets(64'h10_0000, '1, 64'h7fff_ffff_ffff_ffff,
                        64'h8000_0000_0000_0000, '0, 1'b0);
        send_beat(OP_CLEAR, '0, '0, '0, '0);
        load_region(64'h1000, 64'h2000, KIND_CODE);
        load_region(64'h3000, 64'h4000, KIND_DATA);
        load_region(64'h5000, 64'h6000, KIND_HEAP);
        load_region(64'h7000, 64'h8000, KIND_STACK);
        load_region(64'h9000, 64'hA000, KIND_MMAP);
        load_region(64'hB000, 64'hC000, 3'd5);
        load_region(64'hC000, 64'hD000, 3'd7);
        load_region(64'hE000, 64'hE000, KIND_CODE);     // empty
        load_region(64'hF800, 64'hF000, KIND_HEAP);     // inverted, widens span to F000
        scan_word(64'h1234);
        scan_word(64'h3000);                           // region start, data moves by -1
        scan_word(64'h5FFF);                           // last word of heap region
        scan_word(64'h7000);
        scan_word(64'h9800);                           // found, zero net offset
        scan_word(64'hB000);                           // other kind, never moved
        scan_word(64'hC800);
        scan_word(64'hA800);                           // gap inside the span
        scan_word(64'h0800);                           // below the span
        scan_word(64'hF000);                           // span end is exclusive
        load_region('0, '1, KIND_DATA);                // widest possible region
        scan_word('1);
        scan_word('0);

        // --- random episodes under six offset settings
        for (phase = 0; phase < 6; phase++) begin
            drain_results();
            case (phase)
                0: program_offsets(pick_offset(), pick_offset(), pick_offset(),
                                   pick_offset(), pick_offset(), 1'b0);
                1: program_offsets(64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000,
                                   '1, 64'd1, '0, 1'b1);
                2: program_offsets('0, '0, '0, '0, '0, 1'b0);
                3: program_offsets(pick_offset(), pick_offset(), pick_offset(),
                                   pick_offset(), pick_offset(), 1'($urandom));
                4: program_offsets(pick_offset(), pick_offset(), pick_offset(),
                                   pick_offset(), pick_offset(), 1'b1);
                default: program_offsets(rand64(), rand64(), rand64(),
                                         rand64(), rand64(), 1'b0);
            endcase
            @(posedge aclk);
            steady_flow = (phase == 3);        // one long stretch without gaps
            budget = beats_sent + 75;
            run_episode(phase == 1 || phase == 4);
            while (beats_sent < budget) begin
                run_episode($urandom_range(0, 14) == 0);
                // one mid-phase hold-off until the result side has caught up
                if (phase == 5 && !paused) begin
                    drain_results();
                    paused = 1'b1;
                end
            end
        end

        drain_results();
        steady_flow = 1'b0;
        repeat (100) @(posedge aclk);

        $display("Ran %0d beats: %0d scans (%0d found, %0d relocated), %0d clears,",
                 beats_sent, board.scans, board.finds, board.moves, board.clears);
        $display("%0d region loads (%0d refused on a full table), %0d results checked",
                 board.loads, board.drops, board.checked);
        if (board.mismatches == 0)
            $display("pointer_relocation_scanner verification clean");
        else
            $display("pointer_relocation_scanner verification failed");
        $finish;
    end

endmodule
